// ----- rtl/core/ppt_pkg.sv -----
// Package for the pulse period tachometer core.
// Holds shared widths, command and result types, register indexes and states.
// No dependencies.
package ppt_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned TotalW = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned RpmW   = 22;
  localparam int unsigned FreqW  = 24;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgAddrW = 2;

  // Quotient bits produced by the shared restoring divide loop
  localparam int unsigned DivSteps = FreqW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [5:0] RpmScale = 6'd60;
  localparam logic [MsW-1:0] MsMax = {MsW{1'b1}};

  localparam logic [CfgAddrW-1:0] RegCaptureRate = 2'd0;
  localparam logic [CfgAddrW-1:0] RegMinPeriod   = 2'd1;
  localparam logic [CfgAddrW-1:0] RegTimeout     = 2'd2;

  localparam logic [CfgW-1:0] CaptureRateRst = 16'd10000;
  localparam logic [CfgW-1:0] MinPeriodRst   = 16'd50;
  localparam logic [CfgW-1:0] TimeoutRst     = 16'd3000;

  localparam logic ActEdge = 1'b0;
  localparam logic ActTick = 1'b1;

  // Work handed from the front to the back through the queue
  typedef struct packed {
    logic              need_div;
    logic              expired;
    logic [CountW-1:0] period;
    logic [FreqW-1:0]  dvd_freq;
    logic [RpmW-1:0]   dvd_rpm;
    logic [TotalW-1:0] total;
  } cmd_t;

  typedef struct packed {
    logic              timed_out;
    logic              updated;
    logic [TotalW-1:0] total_pulses;
    logic [FreqW-1:0]  frequency_q8;
    logic [RpmW-1:0]   rpm;
  } result_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkEmit
  } back_state_e;

endpackage

// ----- rtl/core/ppt_front.sv -----
// Front end of the tachometer: configuration registers, edge pairing,
// millisecond counter and command generation. Depends on ppt_pkg.
module ppt_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ppt_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [ppt_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_action_i,
  input  logic [ppt_pkg::CountW-1:0]  in_count_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output ppt_pkg::cmd_t               q_cmd_o
);

  logic [ppt_pkg::CfgW-1:0]   rate_q, min_q, tmo_q;
  logic                       await_q, await_d;
  logic [ppt_pkg::CountW-1:0] first_q, first_d;
  logic [ppt_pkg::TotalW-1:0] total_q, total_d;
  logic [ppt_pkg::MsW-1:0]    ms_q, ms_d;
  logic [ppt_pkg::CountW-1:0] period;
  logic                       take;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign q_push_o   = take;
  assign period     = in_count_i - first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= ppt_pkg::CaptureRateRst;
      min_q  <= ppt_pkg::MinPeriodRst;
      tmo_q  <= ppt_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ppt_pkg::RegCaptureRate: rate_q <= cfg_wdata_i;
        ppt_pkg::RegMinPeriod:   min_q  <= cfg_wdata_i;
        ppt_pkg::RegTimeout:     tmo_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    await_d = await_q;
    first_d = first_q;
    total_d = total_q;
    ms_d    = ms_q;
    q_cmd_o.need_div = 1'b0;
    if (in_action_i == ppt_pkg::ActEdge) begin
      total_d = total_q + 1'b1;
      ms_d    = '0;
      if (!await_q) begin
        first_d = in_count_i;
        await_d = 1'b1;
      end else begin
        q_cmd_o.need_div = (period > min_q);
        await_d = 1'b0;
      end
    end else if (ms_q != ppt_pkg::MsMax) begin
      ms_d = ms_q + 1'b1;
    end
    q_cmd_o.expired  = (ms_d > tmo_q);
    q_cmd_o.period   = period;
    q_cmd_o.dvd_freq = {rate_q, 8'h00};
    q_cmd_o.dvd_rpm  = ppt_pkg::RpmW'(rate_q) * ppt_pkg::RpmW'(ppt_pkg::RpmScale);
    q_cmd_o.total    = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q <= 1'b0;
      first_q <= '0;
      total_q <= '0;
      ms_q    <= '0;
    end else if (take) begin
      await_q <= await_d;
      first_q <= first_d;
      total_q <= total_d;
      ms_q    <= ms_d;
    end
  end

endmodule

// ----- rtl/core/ppt_fifo.sv -----
// Two-entry command queue between the front and back of the tachometer.
// Depends on ppt_pkg.
module ppt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ppt_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ppt_pkg::cmd_t head_o
);

  ppt_pkg::cmd_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/core/ppt_back.sv -----
// Back end of the tachometer: held measurement, bit-serial dual divider and
// the output register. Depends on ppt_pkg.
module ppt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  ppt_pkg::cmd_t    q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ppt_pkg::result_t out_o
);

  ppt_pkg::back_state_e state_q, state_d;

  logic [ppt_pkg::RpmW-1:0]    held_rpm_q;
  logic [ppt_pkg::FreqW-1:0]   held_freq_q;
  logic                        out_valid_q;
  ppt_pkg::result_t            out_q;

  logic [ppt_pkg::CountW-1:0]  per_q;
  logic [ppt_pkg::CountW-1:0]  rem_f_q, rem_r_q;
  logic [ppt_pkg::FreqW-1:0]   quo_f_q, quo_r_q;
  logic [ppt_pkg::TotalW-1:0]  total_q;
  logic [ppt_pkg::DivCntW-1:0] cnt_q;

  logic [ppt_pkg::CountW:0]    trial_f, trial_r, per_x;
  logic                        ge_f, ge_r;
  logic                        out_free, load_plain, load_div, emit;

  assign out_free = !out_valid_q || out_ready_i;
  assign per_x    = {1'b0, per_q};
  assign trial_f  = {rem_f_q, quo_f_q[ppt_pkg::FreqW-1]};
  assign trial_r  = {rem_r_q, quo_r_q[ppt_pkg::FreqW-1]};
  assign ge_f     = (trial_f >= per_x);
  assign ge_r     = (trial_r >= per_x);

  always_comb begin
    state_d    = state_q;
    load_plain = 1'b0;
    load_div   = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      ppt_pkg::BkIdle: begin
        if (!q_empty_i) begin
          if (q_head_i.need_div) begin
            load_div = 1'b1;
            state_d  = ppt_pkg::BkDiv;
          end else if (out_free) begin
            load_plain = 1'b1;
          end
        end
      end
      ppt_pkg::BkDiv: begin
        if (cnt_q == ppt_pkg::DivCntW'(ppt_pkg::DivSteps - 1)) begin
          state_d = ppt_pkg::BkEmit;
        end
      end
      ppt_pkg::BkEmit: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ppt_pkg::BkIdle;
        end
      end
      default: state_d = ppt_pkg::BkIdle;
    endcase
  end

  assign q_pop_o = load_plain || load_div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppt_pkg::BkIdle;
      held_rpm_q  <= '0;
      held_freq_q <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (load_div) begin
        cnt_q <= '0;
      end else if (state_q == ppt_pkg::BkDiv) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (load_plain && q_head_i.expired) begin
        held_rpm_q  <= '0;
        held_freq_q <= '0;
      end else if (emit) begin
        held_rpm_q  <= quo_r_q[ppt_pkg::RpmW-1:0];
        held_freq_q <= quo_f_q;
      end
      if (load_plain || emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: divider shift registers and the output payload
  always_ff @(posedge clk_i) begin
    if (load_div) begin
      per_q   <= q_head_i.period;
      rem_f_q <= '0;
      rem_r_q <= '0;
      quo_f_q <= q_head_i.dvd_freq;
      quo_r_q <= ppt_pkg::FreqW'(q_head_i.dvd_rpm);
      total_q <= q_head_i.total;
    end else if (state_q == ppt_pkg::BkDiv) begin
      rem_f_q <= ge_f ? ppt_pkg::CountW'(trial_f - per_x) : trial_f[ppt_pkg::CountW-1:0];
      rem_r_q <= ge_r ? ppt_pkg::CountW'(trial_r - per_x) : trial_r[ppt_pkg::CountW-1:0];
      quo_f_q <= {quo_f_q[ppt_pkg::FreqW-2:0], ge_f};
      quo_r_q <= {quo_r_q[ppt_pkg::FreqW-2:0], ge_r};
    end
    if (load_plain) begin
      out_q.timed_out    <= q_head_i.expired;
      out_q.updated      <= 1'b0;
      out_q.total_pulses <= q_head_i.total;
      out_q.frequency_q8 <= q_head_i.expired ? '0 : held_freq_q;
      out_q.rpm          <= q_head_i.expired ? '0 : held_rpm_q;
    end else if (emit) begin
      out_q.timed_out    <= 1'b0;
      out_q.updated      <= 1'b1;
      out_q.total_pulses <= total_q;
      out_q.frequency_q8 <= quo_f_q;
      out_q.rpm          <= quo_r_q[ppt_pkg::RpmW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/core/pulse_period_tachometer_core.sv -----
// A tick, a first edge or a rejected period passes through the queue entry and the output
//   register; an accepted period also passes through the divide and emit states first.
// Throughput: one transaction per cycle for non-dividing items while the output is not stalled;
//   an accepted period holds the back end through the one-bit-per-cycle restoring divide loop.
// Reset: asynchronous, active low; clears the queue, pairing state, counters, held values,
//   and loads the configuration registers with their defaults.
module pulse_period_tachometer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] capture_count
  input  logic        s_axis_tuser,  // [0] action (0 edge, 1 millisecond tick)
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata   // [21:0] rpm, [45:22] frequency_q8,
                                     // [77:46] total_pulses, [78] measurement_updated,
                                     // [79] timed_out
);

  logic             q_push, q_pop, q_full, q_empty;
  ppt_pkg::cmd_t    q_cmd, q_head;
  ppt_pkg::result_t res;

  // Front: take the transaction, pair edges and decide whether a divide is due
  ppt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_count_i  (s_axis_tdata),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd)
  );

  // Queue: decouple the front from a back end busy dividing
  ppt_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  // Back: divide, hold the measurement and drive the output register
  ppt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = res;

endmodule

// ----- rtl/core/ppt_checker.sv -----
// Port-level checker for the tachometer core, bound to the top level.
// Depends only on the top-level ports.
module ppt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Timed out results read zero rpm and frequency
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[79] |-> m_axis_tdata[45:0] == 46'd0)
    else $error("timed out result not zero");

  // A fresh period comes from an edge, which can never be timed out
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[78] && m_axis_tdata[79]))
    else $error("update and timeout together");

  // rpm scales by 60 and frequency by 256 over the same period
  a_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> {2'b00, m_axis_tdata[21:0]} <= m_axis_tdata[45:22])
    else $error("rpm above frequency");

endmodule

bind pulse_period_tachometer_core ppt_checker u_ppt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
